### sv/intel_hex_lane_record_emitter_assert.svh
// Assertion macros shared by the record emitter modules.
// Needs nothing else; included by the queue and the back end.
`ifndef INTEL_HEX_LANE_RECORD_EMITTER_ASSERT_SVH
`define INTEL_HEX_LANE_RECORD_EMITTER_ASSERT_SVH
`ifndef SYNTHESIS
`define IHEX_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ihex assertion failed");
`define IHEX_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ihex assertion failed");
`else
`define IHEX_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define IHEX_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

### sv/ihex_pkg.sv
// Shared constants, types and helpers of the Intel HEX lane record emitter.
// No dependencies; imported by every module of the block.
package ihex_pkg;

  localparam int REC_BYTES = 32;
  localparam int CHUNK_LEN = 2 * REC_BYTES;
  localparam int IDX_W     = (REC_BYTES > 1) ? $clog2(REC_BYTES) : 1;
  localparam int FILL_W    = $clog2(REC_BYTES + 1);
  localparam int CHUNK_W   = $clog2(CHUNK_LEN + 1);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int Q_DEPTH   = 2;
  localparam int QPTR_W    = $clog2(Q_DEPTH);
  localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [31:0] SEG_MASK = 32'h01fe0000;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_DATA  = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;
  localparam logic [7:0] REC_SEG  = 8'h02;

  localparam logic [6:0] CH_COLON = 7'h3a;
  localparam logic [6:0] CH_CR    = 7'h0d;
  localparam logic [6:0] CH_LF    = 7'h0a;

  typedef enum logic [1:0] {
    CMD_EXT,
    CMD_DATA,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  count;
    logic [15:0] addr16;
    logic [7:0]  seg_hi;
    logic [7:0]  seg_lo;
    logic        bank;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } buf_free_t;

  function automatic logic [6:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return 7'h30 + {3'b000, n};
    end else begin
      return 7'h37 + {3'b000, n};
    end
  endfunction

endpackage

### sv/ihex_front.sv
// Front end: accepts requests, keeps the lane and chunk counters and writes
// kept bytes into the buffer half it owns. Uses ihex_pkg.
module ihex_front import ihex_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] address,
  input  logic [7:0]  data_byte,
  input  logic        section_last,
  input  logic        q_full,
  output logic        push,
  output cmd_t        push_cmd,
  output wr_t         wr,
  input  buf_free_t   buf_free
);

  logic               lane_select;
  logic [FILL_W-1:0]  lane_fill;
  logic [CHUNK_W-1:0] chunk_fill;
  logic [15:0]        lane_total;
  logic [15:0]        record_base;
  logic               bank;
  logic [1:0]         busy;
  logic [1:0]         busy_next;

  logic               is_data;
  logic               accept;
  logic               keep;
  logic               close;
  logic [FILL_W-1:0]  fill_next;
  logic [CHUNK_W-1:0] chunk_inc;
  logic [31:0]        seg;
  logic [31:0]        offset;

  assign is_data   = (req_type == REQ_DATA);
  // A data request waits while the back end still reads the half it would fill.
  assign in_stall  = q_full || (is_data && busy[bank]);
  assign accept    = in_valid && !in_stall;
  assign keep      = (chunk_fill[0] == lane_select) && (lane_fill < FILL_W'(REC_BYTES));
  assign fill_next = lane_fill + FILL_W'(keep);
  assign chunk_inc = chunk_fill + CHUNK_W'(1);
  assign close     = section_last || (chunk_inc == CHUNK_W'(CHUNK_LEN));
  assign seg       = address & SEG_MASK;
  assign offset    = address - seg;

  assign wr.en   = accept && is_data && keep;
  assign wr.addr = {bank, lane_fill[IDX_W-1:0]};
  assign wr.data = data_byte;

  always_comb begin
    push_cmd        = '0;
    push_cmd.bank   = bank;
    push            = 1'b0;
    case (req_type)
      REQ_START: begin
        push_cmd.kind   = CMD_EXT;
        push_cmd.count  = 8'd2;
        push_cmd.seg_hi = seg[20:13];
        push_cmd.seg_lo = seg[12:5];
        push            = accept;
      end
      REQ_DATA: begin
        push_cmd.kind   = CMD_DATA;
        push_cmd.count  = 8'(fill_next);
        push_cmd.addr16 = record_base + lane_total;
        push            = accept && close;
      end
      REQ_END: begin
        push_cmd.kind   = CMD_END;
        push_cmd.addr16 = address[16:1];
        push            = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_comb begin
    busy_next = busy;
    if (buf_free.en) begin
      busy_next[buf_free.bank] = 1'b0;
    end
    if (accept && is_data && close) begin
      busy_next[bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_select <= 1'b0;
      lane_fill   <= '0;
      chunk_fill  <= '0;
      lane_total  <= '0;
      record_base <= '0;
      bank        <= 1'b0;
      busy        <= '0;
    end else begin
      busy <= busy_next;
      if (cfg_write_en) begin
        lane_select <= cfg_write_data;
      end
      if (accept) begin
        case (req_type)
          REQ_START: begin
            record_base <= offset[16:1];
            lane_fill   <= '0;
            chunk_fill  <= '0;
            lane_total  <= '0;
          end
          REQ_DATA: begin
            if (close) begin
              lane_total <= lane_total + 16'(fill_next);
              lane_fill  <= '0;
              chunk_fill <= '0;
              bank       <= ~bank;
            end else begin
              lane_fill  <= fill_next;
              chunk_fill <= chunk_inc;
            end
          end
          default: begin
            lane_fill <= lane_fill;
          end
        endcase
      end
    end
  end

endmodule

### sv/ihex_queue.sv
// Short command queue between the front end and the back end.
// Uses ihex_pkg for the command type and depth.
`include "intel_hex_lane_record_emitter_assert.svh"
module ihex_queue import ihex_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t head
);

  cmd_t              q_mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign head    = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  `IHEX_ASSERT_IMP(a_no_overflow, clk, rst, push, !full)
  `IHEX_ASSERT_IMP(a_no_underflow, clk, rst, pop, q_valid)

endmodule

### sv/ihex_back.sv
// Back end: expands queued commands into record text pieces and holds the
// two-half lane byte buffer. Uses ihex_pkg and the assertion macros.
`include "intel_hex_lane_record_emitter_assert.svh"
module ihex_back import ihex_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       head,
  output logic       pop,
  input  wr_t        wr,
  output buf_free_t  buf_free,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] char_first,
  output logic [6:0] char_second,
  output logic [1:0] char_count,
  output logic       record_end,
  output logic       run_last
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_COLON,
    S_COUNT,
    S_AHI,
    S_ALO,
    S_TYPE,
    S_FETCH,
    S_DATA,
    S_CSUM,
    S_CRLF
  } state_t;

  logic [7:0] lane_mem [MEM_DEPTH];
  logic [7:0] rd_data;

  state_t     state;
  cmd_t       cur;
  logic       second;
  logic [7:0] data_idx;
  logic [7:0] csum;

  logic       out_free;
  logic       piece_go;
  logic [7:0] byte_val;
  logic [7:0] data_val;
  logic [7:0] rec_type;
  logic [6:0] piece_first;
  logic [6:0] piece_second;
  logic [1:0] piece_count;
  logic       piece_end;
  logic       piece_last;
  logic       more_records;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      lane_mem[wr.addr] <= wr.data;
    end
    rd_data <= lane_mem[{cur.bank, data_idx[IDX_W-1:0]}];
  end

  assign out_free     = !out_valid || !out_stall;
  assign pop          = (state == S_IDLE) && q_valid;
  // A block start gives a zero record first and then the segment record.
  assign more_records = (cur.kind == CMD_EXT) && !second;
  assign buf_free.en   = (state == S_CRLF) && out_free && (cur.kind == CMD_DATA);
  assign buf_free.bank = cur.bank;

  always_comb begin
    case (cur.kind)
      CMD_DATA: rec_type = REC_DATA;
      CMD_END:  rec_type = REC_EOF;
      default:  rec_type = REC_SEG;
    endcase
    if (cur.kind == CMD_DATA) begin
      data_val = rd_data;
    end else if (second) begin
      data_val = data_idx[0] ? cur.seg_lo : cur.seg_hi;
    end else begin
      data_val = 8'h00;
    end
  end

  always_comb begin
    byte_val     = 8'h00;
    piece_go     = 1'b0;
    piece_first  = CH_COLON;
    piece_second = 7'h00;
    piece_count  = 2'd2;
    piece_end    = 1'b0;
    piece_last   = 1'b0;
    case (state)
      S_COLON: begin
        piece_go    = out_free;
        piece_count = 2'd1;
      end
      S_COUNT: begin
        piece_go = out_free;
        byte_val = cur.count;
      end
      S_AHI: begin
        piece_go = out_free;
        byte_val = cur.addr16[15:8];
      end
      S_ALO: begin
        piece_go = out_free;
        byte_val = cur.addr16[7:0];
      end
      S_TYPE: begin
        piece_go = out_free;
        byte_val = rec_type;
      end
      S_DATA: begin
        piece_go = out_free;
        byte_val = data_val;
      end
      S_CSUM: begin
        piece_go = out_free;
        byte_val = 8'h00 - csum;
      end
      S_CRLF: begin
        piece_go     = out_free;
        piece_first  = CH_CR;
        piece_second = CH_LF;
        piece_end    = 1'b1;
        piece_last   = !more_records;
      end
      default: begin
        piece_go = 1'b0;
      end
    endcase
    if (state != S_COLON && state != S_CRLF) begin
      piece_first  = hex_char(byte_val[7:4]);
      piece_second = hex_char(byte_val[3:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (piece_go) begin
        out_valid   <= 1'b1;
        char_first  <= piece_first;
        char_second <= piece_second;
        char_count  <= piece_count;
        record_end  <= piece_end;
        run_last    <= piece_last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur    <= head;
            second <= 1'b0;
            state  <= S_COLON;
          end
        end
        S_COLON: begin
          if (piece_go) begin
            csum  <= 8'h00;
            state <= S_COUNT;
          end
        end
        S_COUNT: begin
          if (piece_go) begin
            csum  <= csum + byte_val;
            state <= S_AHI;
          end
        end
        S_AHI: begin
          if (piece_go) begin
            csum  <= csum + byte_val;
            state <= S_ALO;
          end
        end
        S_ALO: begin
          if (piece_go) begin
            csum  <= csum + byte_val;
            state <= S_TYPE;
          end
        end
        S_TYPE: begin
          if (piece_go) begin
            csum     <= csum + byte_val;
            data_idx <= 8'h00;
            state    <= (cur.count == 8'h00) ? S_CSUM : S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_DATA;
        end
        S_DATA: begin
          if (piece_go) begin
            csum     <= csum + byte_val;
            data_idx <= data_idx + 8'd1;
            state    <= ((data_idx + 8'd1) == cur.count) ? S_CSUM : S_FETCH;
          end
        end
        S_CSUM: begin
          if (piece_go) begin
            state <= S_CRLF;
          end
        end
        S_CRLF: begin
          if (piece_go) begin
            if (more_records) begin
              second <= 1'b1;
              state  <= S_COLON;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `IHEX_ASSERT_IMP(a_data_in_range, clk, rst, state == S_DATA, data_idx < cur.count)
  `IHEX_ASSERT_NEXT(a_next_record, clk, rst, piece_go && piece_end && !piece_last, state==S_COLON)

endmodule

### sv/intel_hex_lane_record_emitter.sv
// Top level of the Intel HEX lane record emitter: front end, command queue
// and back end. Uses ihex_pkg and the modules ihex_front, ihex_queue, ihex_back.
//
//   Channel   Handshake                 Payload
//   config    cfg_write_en              cfg_write_data (lane select)
//   input     in_valid / in_stall       req_type, address, data_byte, section_last
//   output    out_valid / out_stall     char_first, char_second, char_count,
//                                       record_end, run_last
//
// A data request is taken while the queue has room and its buffer half is not
// still being read. The back end pops each command and sends its record as pieces:
// colon, count, address high and low, type, each data byte after a fetch state for
// the registered buffer read, checksum, CR LF. A block start runs two records back
// to back. Reset (rst, synchronous) clears all control state. An output stall holds
// the back end only; the front runs on until the queue fills or its half is busy.
module intel_hex_lane_record_emitter import ihex_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] address,
  input  logic [7:0]  data_byte,
  input  logic        section_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  char_first,
  output logic [6:0]  char_second,
  output logic [1:0]  char_count,
  output logic        record_end,
  output logic        run_last
);

  logic      q_full;
  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  logic      q_valid;
  cmd_t      head;
  wr_t       wr;
  buf_free_t buf_free;

  ihex_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .address        (address),
    .data_byte      (data_byte),
    .section_last   (section_last),
    .q_full         (q_full),
    .push           (push),
    .push_cmd       (push_cmd),
    .wr             (wr),
    .buf_free       (buf_free)
  );

  ihex_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  ihex_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .wr          (wr),
    .buf_free    (buf_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_first  (char_first),
    .char_second (char_second),
    .char_count  (char_count),
    .record_end  (record_end),
    .run_last    (run_last)
  );

endmodule

### test/tb_intel_hex_lane_record_emitter.sv
`timescale 1ns / 1ps
// Self-checking testbench for intel_hex_lane_record_emitter: directed and random
// requests, a built-in predictor of the HEX text and a piece-by-piece checker.
// Depends on ihex_pkg for the request codes and on the RTL of the block.
module tb_intel_hex_lane_record_emitter;

  localparam int RECORD_BYTES = 32;
  localparam int CHUNK_BYTES  = 2 * RECORD_BYTES;
  localparam logic [31:0] SEGMENT_MASK = 32'h01fe0000;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [7:0] KIND_DATA = 8'h00;
  localparam logic [7:0] KIND_EOF  = 8'h01;
  localparam logic [7:0] KIND_SEG  = 8'h02;
  localparam logic [6:0] ASCII_COLON = 7'h3a;
  localparam logic [6:0] ASCII_CR    = 7'h0d;
  localparam logic [6:0] ASCII_LF    = 7'h0a;
  localparam int DRAIN_CYCLES = 200;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [6:0] first;
    logic [6:0] second;
    logic [1:0] count;
    logic       rec_end;
    logic       run_last;
  } piece_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic        cfg_write_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = ihex_pkg::REQ_START;
  logic [31:0] address = 32'd0;
  logic [7:0]  data_byte = 8'd0;
  logic        section_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  char_first;
  logic [6:0]  char_second;
  logic [1:0]  char_count;
  logic        record_end;
  logic        run_last;

  intel_hex_lane_record_emitter uut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .address(address),
    .data_byte(data_byte),
    .section_last(section_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .char_first(char_first),
    .char_second(char_second),
    .char_count(char_count),
    .record_end(record_end),
    .run_last(run_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state, kept apart from the block.
  piece_t      expected_pieces[$];
  logic        lane_sel = 1'b0;
  logic [7:0]  kept_bytes [RECORD_BYTES];
  int          kept_fill = 0;
  int          chunk_pos = 0;
  logic [15:0] emitted_total = 16'd0;
  logic [15:0] section_base = 16'd0;

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int requests_sent = 0;
  int pieces_checked = 0;
  int records_seen = 0;
  int cycle_count = 0;

  function automatic logic [6:0] nibble_ascii(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + {4'd0, n};
    end else begin
      c = 8'h41 + {4'd0, n} - 8'd10;
    end
    return c[6:0];
  endfunction

  function automatic void push_piece(input logic [6:0] a, input logic [6:0] b,
                                     input logic [1:0] n, input logic e);
    piece_t p;
    p.first = a;
    p.second = b;
    p.count = n;
    p.rec_end = e;
    p.run_last = 1'b0;
    expected_pieces.push_back(p);
  endfunction

  function automatic void push_hex(input logic [7:0] v);
    push_piece(nibble_ascii(v[7:4]), nibble_ascii(v[3:0]), 2'd2, 1'b0);
  endfunction

  function automatic void push_record(input logic [7:0] count, input logic [15:0] addr16,
                                      input logic [7:0] kind,
                                      input logic [7:0] payload [RECORD_BYTES]);
    logic [7:0] sum;
    int i;
    sum = count + addr16[7:0] + addr16[15:8] + kind;
    push_piece(ASCII_COLON, 7'd0, 2'd1, 1'b0);
    push_hex(count);
    push_hex(addr16[15:8]);
    push_hex(addr16[7:0]);
    push_hex(kind);
    for (i = 0; i < count; i++) begin
      push_hex(payload[i]);
      sum = sum + payload[i];
    end
    push_hex(8'd0 - sum);
    push_piece(ASCII_CR, ASCII_LF, 2'd2, 1'b1);
  endfunction

  // Works out the pieces that one accepted request causes.
  function automatic void encode_request(input logic [1:0] req, input logic [31:0] addr,
                                         input logic [7:0] b, input logic last);
    int start;
    logic [31:0] seg;
    logic [31:0] offset;
    logic [7:0] ext [RECORD_BYTES];
    piece_t p;
    start = expected_pieces.size();
    case (req)
      ihex_pkg::REQ_START: begin
        ext = '{default: 8'd0};
        push_record(8'd2, 16'd0, KIND_SEG, ext);
        seg = addr & SEGMENT_MASK;
        ext[0] = seg[20:13];
        ext[1] = seg[12:5];
        push_record(8'd2, 16'd0, KIND_SEG, ext);
        offset = (addr - seg) >> 1;
        section_base = offset[15:0];
        kept_fill = 0;
        chunk_pos = 0;
        emitted_total = 16'd0;
      end
      ihex_pkg::REQ_DATA: begin
        if (chunk_pos[0] == lane_sel && kept_fill < RECORD_BYTES) begin
          kept_bytes[kept_fill] = b;
          kept_fill++;
        end
        chunk_pos++;
        if (chunk_pos >= CHUNK_BYTES || last) begin
          push_record(8'(kept_fill), section_base + emitted_total, KIND_DATA, kept_bytes);
          emitted_total = emitted_total + 16'(kept_fill);
          kept_fill = 0;
          chunk_pos = 0;
        end
      end
      ihex_pkg::REQ_END: begin
        push_record(8'd0, addr[16:1], KIND_EOF, kept_bytes);
      end
      default: begin
      end
    endcase
    if (expected_pieces.size() > start) begin
      p = expected_pieces.pop_back();
      p.run_last = 1'b1;
      expected_pieces.push_back(p);
    end
  endfunction

  // One process predicts and checks, so that a request and a piece seen at the
  // same edge are always handled in the same order.
  always @(posedge clk) begin
    piece_t got;
    piece_t want;
    if (!rst) begin
      if (cfg_write_en) begin
        lane_sel = cfg_write_data;
      end
      if (in_valid && !in_stall) begin
        encode_request(req_type, address, data_byte, section_last);
      end
      if (out_valid && !out_stall) begin
        got = '{char_first, char_second, char_count, record_end, run_last};
        pieces_checked++;
        if (record_end) begin
          records_seen++;
        end
        if (expected_pieces.size() == 0) begin
          errors++;
          $display("%0t: unexpected piece: expected none, actual %h %h %0d %b %b", $time,
                   got.first, got.second, got.count, got.rec_end, got.run_last);
        end else begin
          want = expected_pieces.pop_front();
          if (got.first !== want.first || got.second !== want.second ||
              got.count !== want.count || got.rec_end !== want.rec_end ||
              got.run_last !== want.run_last) begin
            errors++;
            $display("%0t: piece mismatch: expected %h %h %0d %b %b, actual %h %h %0d %b %b",
                     $time, want.first, want.second, want.count, want.rec_end,
                     want.run_last, got.first, got.second, got.count, got.rec_end,
                     got.run_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_intel_hex_lane_record_emitter: errors");
      $finish;
    end
  end

  // Each cycle before the request the sender stays idle with the set odds.
  task automatic send_request(input logic [1:0] req, input logic [31:0] addr,
                              input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    address <= addr;
    data_byte <= b;
    section_last <= last;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic send_start(input logic [31:0] addr);
    send_request(ihex_pkg::REQ_START, addr, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    send_request(ihex_pkg::REQ_DATA, $urandom, b, last);
  endtask

  task automatic send_end(input logic [31:0] addr);
    send_request(ihex_pkg::REQ_END, addr, 8'($urandom), 1'($urandom));
  endtask

  // Stops sending and lets the block run dry, including any work on requests
  // that cause no pieces.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (expected_pieces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_lane(input logic lane);
    wait_until_drained();
    cfg_write_en <= 1'b1;
    cfg_write_data <= lane;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic test_data_before_start();
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_block_start_extremes();
    send_start(32'hffff_ffff);
    send_byte(8'h00, 1'b0);
    send_byte(8'ha5, 1'b0);
    send_byte(8'hff, 1'b1);
    send_start(32'h0000_0000);
    send_byte(8'h5a, 1'b1);
  endtask

  task automatic test_end_and_unknown();
    send_end(32'hffff_ffff);
    send_end(32'h0000_0000);
    send_request(REQ_UNKNOWN, 32'hffff_ffff, 8'hff, 1'b1);
    send_end(32'h0001_2345);
  endtask

  // With the odd lane a one-byte section keeps nothing and gives an empty record.
  task automatic test_odd_lane_empty_record();
    write_lane(1'b1);
    send_start(32'h0123_4567);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b1);
  endtask

  // A section longer than one chunk closes a full record and then a short one,
  // whose address wraps past the top of the 16-bit range.
  task automatic test_full_chunk_wrap();
    int k;
    send_start(32'h0001_fff0);
    for (k = 0; k < CHUNK_BYTES + 2; k++) begin
      send_byte(8'($urandom), k == CHUNK_BYTES + 1);
    end
  endtask

  task automatic test_random_sections(input int idle, input int stall, input logic lane,
                                      input bit pause_midway, input int quota);
    int done;
    int len;
    int k;
    logic [1:0] req;
    bit paused;
    write_lane(lane);
    idle_pct = idle;
    stall_pct = stall;
    done = 0;
    paused = 1'b0;
    while (done < quota) begin
      if (pause_midway && !paused && done >= quota / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_pieces.size() != 0);
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 80) begin
        // Well-formed section, now and then left open so that the requests after
        // it meet a section that was never closed.
        if ($urandom_range(0, 3) == 0) begin
          send_start({7'($urandom), 8'hff, 17'h1fff0 | 17'($urandom_range(0, 15))});
        end else begin
          send_start($urandom);
        end
        len = $urandom_range(1, 10);
        for (k = 0; k < len; k++) begin
          send_byte(8'($urandom), (k == len - 1) && ($urandom_range(0, 9) != 0));
        end
        done += 1 + len;
        if ($urandom_range(0, 2) == 0) begin
          send_end($urandom);
          done++;
        end
      end else begin
        req = 2'($urandom_range(0, 3));
        send_request(req, $urandom, 8'($urandom), 1'($urandom));
        if (req != REQ_UNKNOWN) begin
          done++;
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_data_before_start();
    test_block_start_extremes();
    test_end_and_unknown();
    test_odd_lane_empty_record();
    test_full_chunk_wrap();
    test_random_sections(0, 0, 1'b0, 1'b0, 14);
    test_random_sections(67, 0, 1'b1, 1'b1, 14);
    test_random_sections(0, 67, 1'b0, 1'b0, 14);
    test_random_sections(18, 18, 1'b1, 1'b0, 14);
    wait_until_drained();
    $display("Covered %0d requests over four handshake phases and both lane selects,",
             requests_sent);
    $display("checking %0d pieces in %0d records.", pieces_checked, records_seen);
    if (errors == 0) begin
      $display("tb_intel_hex_lane_record_emitter: clean");
    end else begin
      $display("tb_intel_hex_lane_record_emitter: errors");
    end
    $finish;
  end

endmodule
